// ===== hdl/sme_pkg.sv =====
`default_nettype none
package sme_pkg;

    localparam int SME_STACK_DEPTH = 1024;
    localparam int SME_LOCAL_DEPTH = 1024;
    localparam int SME_CALL_DEPTH  = 64;

    localparam logic [4:0] OP_INVALID   = 5'd0;
    localparam logic [4:0] OP_RETURN    = 5'd1;
    localparam logic [4:0] OP_CALL      = 5'd2;
    localparam logic [4:0] OP_JZ        = 5'd3;
    localparam logic [4:0] OP_JUMP      = 5'd4;
    localparam logic [4:0] OP_ADD       = 5'd5;
    localparam logic [4:0] OP_SUB       = 5'd6;
    localparam logic [4:0] OP_MUL       = 5'd7;
    localparam logic [4:0] OP_DIV       = 5'd8;
    localparam logic [4:0] OP_MOD       = 5'd9;
    localparam logic [4:0] OP_GT        = 5'd10;
    localparam logic [4:0] OP_LT        = 5'd11;
    localparam logic [4:0] OP_GE        = 5'd12;
    localparam logic [4:0] OP_LE        = 5'd13;
    localparam logic [4:0] OP_EQ        = 5'd14;
    localparam logic [4:0] OP_NE        = 5'd15;
    localparam logic [4:0] OP_INC       = 5'd16;
    localparam logic [4:0] OP_DEC       = 5'd17;
    localparam logic [4:0] OP_STORE_G   = 5'd18;
    localparam logic [4:0] OP_STORE_L   = 5'd19;
    localparam logic [4:0] OP_LOAD_IMM  = 5'd20;
    localparam logic [4:0] OP_LOAD_G    = 5'd21;
    localparam logic [4:0] OP_LOAD_L    = 5'd22;
    localparam logic [4:0] OP_EXIT      = 5'd23;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_EXIT      = 4'd1;
    localparam logic [3:0] ST_INVALID   = 4'd2;
    localparam logic [3:0] ST_DIV_ZERO  = 4'd3;
    localparam logic [3:0] ST_UNDERFLOW = 4'd4;
    localparam logic [3:0] ST_OVERFLOW  = 4'd5;
    localparam logic [3:0] ST_CALL_OVF  = 4'd6;
    localparam logic [3:0] ST_RET_TOP   = 4'd7;
    localparam logic [3:0] ST_LOCAL_OVF = 4'd8;

    // instruction classes
    localparam logic [3:0] CL_INVALID = 4'd0;
    localparam logic [3:0] CL_RET     = 4'd1;
    localparam logic [3:0] CL_CALL    = 4'd2;
    localparam logic [3:0] CL_JZ      = 4'd3;
    localparam logic [3:0] CL_JUMP    = 4'd4;
    localparam logic [3:0] CL_BIN     = 4'd5;
    localparam logic [3:0] CL_UNARY   = 4'd6;
    localparam logic [3:0] CL_STORE   = 4'd7;
    localparam logic [3:0] CL_IMM     = 4'd8;
    localparam logic [3:0] CL_LOAD    = 4'd9;
    localparam logic [3:0] CL_EXIT    = 4'd10;

    typedef struct packed {
        logic [3:0]  cls;
        logic [4:0]  op;
        logic        global_slot;
        logic [63:0] imm;
        logic [15:0] slot;
        logic [7:0]  nargs;
        logic [7:0]  nlocals;
    } t_dec;

endpackage
`default_nettype wire

// ===== hdl/sme_in_if.sv =====
`default_nettype none
interface sme_in_if;
    logic               valid;
    logic               ready;
    logic [4:0]         operation;
    logic signed [63:0] immediate;
    logic [15:0]        target_or_slot;
    logic [7:0]         arg_count;
    logic [7:0]         local_count;

    modport source (output valid, operation, immediate, target_or_slot, arg_count,
                    local_count, input ready);
    modport sink (input valid, operation, immediate, target_or_slot, arg_count,
                  local_count, output ready);
endinterface
`default_nettype wire

// ===== hdl/sme_out_if.sv =====
`default_nettype none
interface sme_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic [15:0] next_pc;
    logic [15:0] next_segment;
    logic [63:0] top_value;
    logic [10:0] stack_depth;
    logic [6:0]  call_depth;

    modport source (output valid, status, next_pc, next_segment, top_value, stack_depth,
                    call_depth, input ready);
    modport sink (input valid, status, next_pc, next_segment, top_value, stack_depth,
                  call_depth, output ready);
endinterface
`default_nettype wire

// ===== hdl/sme_front.sv =====
`default_nettype none
module sme_front
    import sme_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [4:0]  i_operation,
    input  wire logic [63:0] i_immediate,
    input  wire logic [15:0] i_target_or_slot,
    input  wire logic [7:0]  i_arg_count,
    input  wire logic [7:0]  i_local_count,
    output logic             o_valid,
    input  wire logic        i_ready,
    output t_dec             o_dec
);

    logic r_valid;
    t_dec r_dec;
    t_dec n_dec;

    always_comb begin
        n_dec.op          = i_operation;
        n_dec.imm         = i_immediate;
        n_dec.slot        = i_target_or_slot;
        n_dec.nargs       = i_arg_count;
        n_dec.nlocals     = i_local_count;
        n_dec.global_slot = (i_operation == OP_STORE_G) || (i_operation == OP_LOAD_G);
        case (i_operation)
            OP_RETURN:                  n_dec.cls = CL_RET;
            OP_CALL:                    n_dec.cls = CL_CALL;
            OP_JZ:                      n_dec.cls = CL_JZ;
            OP_JUMP:                    n_dec.cls = CL_JUMP;
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_GT, OP_LT, OP_GE, OP_LE,
            OP_EQ, OP_NE:               n_dec.cls = CL_BIN;
            OP_INC, OP_DEC:             n_dec.cls = CL_UNARY;
            OP_STORE_G, OP_STORE_L:     n_dec.cls = CL_STORE;
            OP_LOAD_IMM:                n_dec.cls = CL_IMM;
            OP_LOAD_G, OP_LOAD_L:       n_dec.cls = CL_LOAD;
            OP_EXIT:                    n_dec.cls = CL_EXIT;
            default:                    n_dec.cls = CL_INVALID;
        endcase
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_dec   = r_dec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_dec <= n_dec;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/sme_queue.sv =====
`default_nettype none
module sme_queue
    import sme_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_dec i_dec,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_dec      o_dec
);

    t_dec       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_dec   = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
        if (push) begin
            r_mem[r_wp] <= i_dec;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/sme_back.sv =====
`default_nettype none
module sme_back
    import sme_pkg::*;
#(
    parameter int STACK_DEPTH = SME_STACK_DEPTH,
    parameter int LOCAL_DEPTH = SME_LOCAL_DEPTH,
    parameter int CALL_DEPTH  = SME_CALL_DEPTH,
    localparam int LC_W = $clog2(LOCAL_DEPTH + 1)
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire t_dec            i_dec,
    input  wire logic            i_gc_wr,
    input  wire logic [LC_W-1:0] i_gc,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output logic [3:0]           o_status,
    output logic [15:0]          o_next_pc,
    output logic [15:0]          o_next_segment,
    output logic [63:0]          o_top_value,
    output logic [10:0]          o_stack_depth,
    output logic [6:0]           o_call_depth
);

    localparam int SP_W = $clog2(STACK_DEPTH + 1);
    localparam int SA_W = $clog2(STACK_DEPTH);
    localparam int LA_W = $clog2(LOCAL_DEPTH);
    localparam int FC_W = $clog2(CALL_DEPTH + 1);
    localparam int CA_W = $clog2(CALL_DEPTH);
    localparam int RS_W = 32 + 2 * LC_W;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_BIN     = 4'd1;
    localparam logic [3:0] S_MUL     = 4'd2;
    localparam logic [3:0] S_DIV     = 4'd3;
    localparam logic [3:0] S_LOADTOP = 4'd4;
    localparam logic [3:0] S_LDL     = 4'd5;
    localparam logic [3:0] S_RET     = 4'd6;
    localparam logic [3:0] S_CALL    = 4'd7;
    localparam logic [3:0] S_CALLTOP = 4'd8;
    localparam logic [3:0] S_RESP    = 4'd9;

    // memories
    logic [63:0]   stack_mem [STACK_DEPTH];
    logic [63:0]   local_mem [LOCAL_DEPTH];
    logic [RS_W-1:0] ret_mem [CALL_DEPTH];
    logic [63:0]   r_s_rdata;
    logic [63:0]   r_l_rdata;
    logic [RS_W-1:0] r_c_rdata;

    logic            s_we;
    logic [SA_W-1:0] s_waddr;
    logic [63:0]     s_wdata;
    logic [SA_W-1:0] s_raddr;
    logic            l_we;
    logic [LA_W-1:0] l_waddr;
    logic [63:0]     l_wdata;
    logic [LA_W-1:0] l_raddr;
    logic            c_we;
    logic [CA_W-1:0] c_waddr;
    logic [RS_W-1:0] c_wdata;
    logic [CA_W-1:0] c_raddr;

    // machine state
    logic [3:0]      r_state,  n_state;
    logic [SP_W-1:0] r_sp,     n_sp;
    logic [63:0]     r_top,    n_top;
    logic [15:0]     r_pc,     n_pc;
    logic [15:0]     r_seg,    n_seg;
    logic [LC_W-1:0] r_base,   n_base;
    logic [LC_W-1:0] r_size,   n_size;
    logic [FC_W-1:0] r_fc,     n_fc;
    logic [3:0]      r_status, n_status;
    t_dec            r_dec,    n_dec;
    logic [7:0]      r_cnt,    n_cnt;
    logic [LC_W-1:0] r_nb,     n_nb;
    logic [63:0]     r_a,      n_a;
    logic [63:0]     r_acc,    n_acc;
    logic [63:0]     r_prod,   n_prod;
    logic [63:0]     r_rem,    n_rem;

    logic            r_ovalid;
    logic [3:0]      r_ostatus;
    logic [15:0]     r_opc;
    logic [15:0]     r_oseg;
    logic [63:0]     r_otop;
    logic [SP_W-1:0] r_osp;
    logic [FC_W-1:0] r_ofc;
    logic            out_load;

    always_ff @(posedge i_clk) begin
        if (s_we) stack_mem[s_waddr] <= s_wdata;
        r_s_rdata <= stack_mem[s_raddr];
        if (l_we) local_mem[l_waddr] <= l_wdata;
        r_l_rdata <= local_mem[l_raddr];
        if (c_we) ret_mem[c_waddr] <= c_wdata;
        r_c_rdata <= ret_mem[c_raddr];
    end

    always_comb begin
        logic [3:0]  st;
        logic [15:0] pc_inc;
        logic [31:0] sp32;
        logic [31:0] nb32;
        logic [31:0] addr32;
        logic [31:0] limit32;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] val;
        logic        commit;
        logic [31:0] mx;
        logic [31:0] my;
        logic [64:0] rem2;
        logic [63:0] rem_n;
        logic [63:0] q_n;

        n_state  = r_state;
        n_sp     = r_sp;
        n_top    = r_top;
        n_pc     = r_pc;
        n_seg    = r_seg;
        n_base   = r_base;
        n_size   = r_size;
        n_fc     = r_fc;
        n_status = r_status;
        n_dec    = r_dec;
        n_cnt    = r_cnt;
        n_nb     = r_nb;
        n_a      = r_a;
        n_acc    = r_acc;
        n_prod   = r_prod;
        n_rem    = r_rem;
        s_we     = 1'b0;
        s_waddr  = SA_W'(r_sp - SP_W'(2));
        s_wdata  = r_top;
        s_raddr  = SA_W'(r_sp - SP_W'(2));
        l_we     = 1'b0;
        l_waddr  = '0;
        l_wdata  = r_top;
        l_raddr  = '0;
        c_we     = 1'b0;
        c_waddr  = CA_W'(r_fc);
        c_wdata  = {r_pc + 16'd1, r_seg, r_base, r_size};
        c_raddr  = CA_W'(r_fc - FC_W'(1));
        o_ready  = 1'b0;
        out_load = 1'b0;
        st       = ST_OK;
        val      = '0;
        commit   = 1'b0;
        a        = r_s_rdata;
        b        = r_top;
        mx       = '0;
        my       = '0;
        rem2     = '0;
        rem_n    = '0;
        q_n      = '0;
        pc_inc   = r_pc + 16'd1;
        sp32     = 32'(r_sp);
        nb32     = 32'(r_base) + 32'(r_size);
        limit32  = i_dec.global_slot ? 32'(i_gc) : 32'(r_size);
        addr32   = i_dec.global_slot ? 32'(i_dec.slot) : 32'(r_base) + 32'(i_dec.slot);

        if (i_gc_wr && r_fc == '0) begin
            n_size = i_gc;
        end

        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_dec = i_dec;
                    case (i_dec.cls)
                        CL_RET:   if (r_fc == '0) st = ST_RET_TOP;
                        CL_CALL: begin
                            if (32'(r_fc) >= CALL_DEPTH) st = ST_CALL_OVF;
                            else if (i_dec.nargs > i_dec.nlocals) st = ST_INVALID;
                            else if (sp32 < 32'(i_dec.nargs)) st = ST_UNDERFLOW;
                            else if (nb32 > LOCAL_DEPTH ||
                                     32'(i_dec.nlocals) > LOCAL_DEPTH - nb32)
                                st = ST_LOCAL_OVF;
                        end
                        CL_JZ, CL_UNARY: if (sp32 < 32'd1) st = ST_UNDERFLOW;
                        CL_JUMP:  st = ST_OK;
                        CL_BIN: begin
                            if (sp32 < 32'd2) st = ST_UNDERFLOW;
                            else if ((i_dec.op == OP_DIV || i_dec.op == OP_MOD) &&
                                     r_top == '0)
                                st = ST_DIV_ZERO;
                        end
                        CL_STORE: begin
                            if (32'(i_dec.slot) >= limit32 || addr32 >= LOCAL_DEPTH)
                                st = ST_INVALID;
                            else if (sp32 < 32'd1) st = ST_UNDERFLOW;
                        end
                        CL_IMM:   if (sp32 >= STACK_DEPTH) st = ST_OVERFLOW;
                        CL_LOAD: begin
                            if (32'(i_dec.slot) >= limit32 || addr32 >= LOCAL_DEPTH)
                                st = ST_INVALID;
                            else if (sp32 >= STACK_DEPTH) st = ST_OVERFLOW;
                        end
                        CL_EXIT:  st = ST_EXIT;
                        default:  st = ST_INVALID;
                    endcase
                    n_status = st;
                    n_state  = S_RESP;
                    if (st == ST_OK) begin
                        case (i_dec.cls)
                            CL_RET: begin
                                n_fc    = r_fc - FC_W'(1);
                                n_state = S_RET;
                            end
                            CL_CALL: begin
                                c_we    = 1'b1;
                                n_fc    = r_fc + FC_W'(1);
                                n_nb    = LC_W'(nb32);
                                n_cnt   = i_dec.nargs;
                                n_state = S_CALL;
                            end
                            CL_JZ: begin
                                n_pc    = (r_top == '0) ? i_dec.slot : pc_inc;
                                n_sp    = r_sp - SP_W'(1);
                                n_state = S_LOADTOP;
                            end
                            CL_JUMP:  n_pc = i_dec.slot;
                            CL_BIN:   n_state = S_BIN;
                            CL_UNARY: begin
                                val     = (i_dec.op == OP_INC) ? r_top + 64'd1
                                                               : r_top - 64'd1;
                                s_we    = 1'b1;
                                s_waddr = SA_W'(r_sp - SP_W'(1));
                                s_wdata = val;
                                n_top   = val;
                                n_pc    = pc_inc;
                            end
                            CL_STORE: begin
                                l_we    = 1'b1;
                                l_waddr = LA_W'(addr32);
                                n_sp    = r_sp - SP_W'(1);
                                n_pc    = pc_inc;
                                n_state = S_LOADTOP;
                            end
                            CL_IMM: begin
                                s_we    = 1'b1;
                                s_waddr = SA_W'(r_sp);
                                s_wdata = i_dec.imm;
                                n_top   = i_dec.imm;
                                n_sp    = r_sp + SP_W'(1);
                                n_pc    = pc_inc;
                            end
                            CL_LOAD: begin
                                l_raddr = LA_W'(addr32);
                                n_state = S_LDL;
                            end
                            default: n_state = S_RESP;
                        endcase
                    end
                end
            end
            S_BIN: begin
                case (r_dec.op)
                    OP_ADD: val = a + b;
                    OP_SUB: val = a - b;
                    OP_GT:  val = {63'd0, a > b};
                    OP_LT:  val = {63'd0, a < b};
                    OP_GE:  val = {63'd0, a >= b};
                    OP_LE:  val = {63'd0, a <= b};
                    OP_EQ:  val = {63'd0, a == b};
                    default: val = {63'd0, a != b};
                endcase
                n_a     = a;
                n_cnt   = '0;
                n_acc   = '0;
                n_rem   = '0;
                if (r_dec.op == OP_MUL) begin
                    n_state = S_MUL;
                end else if (r_dec.op == OP_DIV || r_dec.op == OP_MOD) begin
                    n_state = S_DIV;
                end else begin
                    commit = 1'b1;
                end
            end
            S_MUL: begin
                // low 64 bits only: lo*lo + (lo*hi + hi*lo) << 32
                mx     = (r_cnt[1:0] == 2'd2) ? r_a[63:32] : r_a[31:0];
                my     = (r_cnt[1:0] == 2'd1) ? r_top[63:32] : r_top[31:0];
                n_prod = 64'(mx) * 64'(my);
                n_cnt  = r_cnt + 8'd1;
                if (r_cnt[1:0] == 2'd1) n_acc = r_prod;
                if (r_cnt[1:0] == 2'd2) n_acc = r_acc + {r_prod[31:0], 32'd0};
                if (r_cnt[1:0] == 2'd3) begin
                    val    = r_acc + {r_prod[31:0], 32'd0};
                    commit = 1'b1;
                end
            end
            S_DIV: begin
                // restoring division, one quotient bit a cycle; r_a shifts into quotient
                rem2 = {r_rem, r_a[63]};
                if (rem2 >= {1'b0, r_top}) begin
                    rem_n = 64'(rem2 - {1'b0, r_top});
                    q_n   = {r_a[62:0], 1'b1};
                end else begin
                    rem_n = rem2[63:0];
                    q_n   = {r_a[62:0], 1'b0};
                end
                n_rem = rem_n;
                n_a   = q_n;
                n_cnt = r_cnt + 8'd1;
                if (r_cnt == 8'd63) begin
                    val    = (r_dec.op == OP_DIV) ? q_n : rem_n;
                    commit = 1'b1;
                end
            end
            S_LOADTOP: begin
                n_top   = r_s_rdata;
                n_state = S_RESP;
            end
            S_LDL: begin
                s_we    = 1'b1;
                s_waddr = SA_W'(r_sp);
                s_wdata = r_l_rdata;
                n_top   = r_l_rdata;
                n_sp    = r_sp + SP_W'(1);
                n_pc    = pc_inc;
                n_state = S_RESP;
            end
            S_RET: begin
                n_pc    = r_c_rdata[RS_W-1 -: 16];
                n_seg   = r_c_rdata[RS_W-17 -: 16];
                n_base  = r_c_rdata[2*LC_W-1 -: LC_W];
                n_size  = r_c_rdata[LC_W-1:0];
                n_state = S_RESP;
            end
            S_CALL: begin
                // top of stack goes to the highest argument slot first
                if (r_cnt == 8'd0) begin
                    n_base  = r_nb;
                    n_size  = LC_W'(r_dec.nlocals);
                    n_seg   = r_dec.slot;
                    n_pc    = '0;
                    n_state = S_RESP;
                end else begin
                    l_we    = 1'b1;
                    l_waddr = LA_W'(32'(r_nb) + 32'(r_cnt) - 32'd1);
                    n_sp    = r_sp - SP_W'(1);
                    n_cnt   = r_cnt - 8'd1;
                    n_state = S_CALLTOP;
                end
            end
            S_CALLTOP: begin
                n_top   = r_s_rdata;
                n_state = S_CALL;
            end
            S_RESP: begin
                if (!r_ovalid || i_ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (commit) begin
            s_we    = 1'b1;
            s_waddr = SA_W'(r_sp - SP_W'(2));
            s_wdata = val;
            n_top   = val;
            n_sp    = r_sp - SP_W'(1);
            n_pc    = pc_inc;
            n_state = S_RESP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_sp     <= '0;
            r_pc     <= '0;
            r_seg    <= '0;
            r_base   <= '0;
            r_size   <= '0;
            r_fc     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sp    <= n_sp;
            r_pc    <= n_pc;
            r_seg   <= n_seg;
            r_base  <= n_base;
            r_size  <= n_size;
            r_fc    <= n_fc;
            if (out_load)     r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
        end
        r_top    <= n_top;
        r_status <= n_status;
        r_dec    <= n_dec;
        r_cnt    <= n_cnt;
        r_nb     <= n_nb;
        r_a      <= n_a;
        r_acc    <= n_acc;
        r_prod   <= n_prod;
        r_rem    <= n_rem;
        if (out_load) begin
            r_ostatus <= r_status;
            r_opc     <= r_pc;
            r_oseg    <= r_seg;
            r_otop    <= (r_sp == '0) ? 64'd0 : r_top;
            r_osp     <= r_sp;
            r_ofc     <= r_fc;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_status       = r_ostatus;
    assign o_next_pc      = r_opc;
    assign o_next_segment = r_oseg;
    assign o_top_value    = r_otop;
    assign o_stack_depth  = 11'(r_osp);
    assign o_call_depth   = 7'(r_ofc);

endmodule
`default_nettype wire

// ===== hdl/stack_machine_execute_unit.sv =====
// Channel    Dir  Handshake          Payload
// i_cmd      in   valid/ready        operation, immediate, target_or_slot, arg/local counts
// o_res      out  valid/ready        status, next_pc, next_segment, top_value, depths
// APB        in   psel/penable/pwrite global_count at byte address 0
//
// Execute-stage path: jump, load_imm, inc/dec and error/exit go from S_IDLE straight
// to S_RESP; pops, loads, return and add/sub/compare pass S_LOADTOP, S_LDL, S_RET or
// S_BIN; mul adds S_MUL (three 32x32 partial products on one multiplier); div/mod adds
// S_DIV (one quotient bit a cycle); call loops S_CALL/S_CALLTOP (one stack read per
// argument). Stack, locals and return frames sit in single-port-read memories with
// registered read data. Reset (i_rst_n low, synchronous) empties both stacks and the queue.
// A decode register and a two-entry queue keep taking transactions, until both are
// full, while the execute stage works or the result register waits on o_res.ready.
`default_nettype none
module stack_machine_execute_unit
    import sme_pkg::*;
#(
    parameter int STACK_DEPTH = SME_STACK_DEPTH,
    parameter int LOCAL_DEPTH = SME_LOCAL_DEPTH,
    parameter int CALL_DEPTH  = SME_CALL_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    sme_in_if.sink           i_cmd,
    sme_out_if.source        o_res,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int LC_W = $clog2(LOCAL_DEPTH + 1);

    logic            r_gc;
    logic [LC_W-1:0] r_gcount;
    logic [LC_W-1:0] n_gcount;
    logic            gc_wr;
    logic [31:0]     wval;

    logic f_valid;
    logic f_ready;
    t_dec f_dec;
    logic q_valid;
    logic q_ready;
    t_dec q_dec;

    assign pready = 1'b1;
    assign gc_wr  = psel && penable && pwrite && !paddr[2];
    assign wval   = {21'd0, pwdata[10:0]};
    assign n_gcount = (wval > LOCAL_DEPTH) ? LC_W'(LOCAL_DEPTH) : LC_W'(wval);
    assign prdata = paddr[2] ? 32'd0 : 32'(r_gcount);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gcount <= '0;
            r_gc     <= 1'b0;
        end else begin
            r_gc <= gc_wr;
            if (gc_wr) r_gcount <= n_gcount;
        end
    end

    sme_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_cmd.valid),
        .o_ready          (i_cmd.ready),
        .i_operation      (i_cmd.operation),
        .i_immediate      (i_cmd.immediate),
        .i_target_or_slot (i_cmd.target_or_slot),
        .i_arg_count      (i_cmd.arg_count),
        .i_local_count    (i_cmd.local_count),
        .o_valid          (f_valid),
        .i_ready          (f_ready),
        .o_dec            (f_dec)
    );

    sme_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_dec   (f_dec),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_dec   (q_dec)
    );

    // frame_size takes global_count from the registered write strobe while no call is open
    sme_back #(
        .STACK_DEPTH (STACK_DEPTH),
        .LOCAL_DEPTH (LOCAL_DEPTH),
        .CALL_DEPTH  (CALL_DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (q_valid),
        .o_ready        (q_ready),
        .i_dec          (q_dec),
        .i_gc_wr        (r_gc),
        .i_gc           (r_gcount),
        .o_valid        (o_res.valid),
        .i_ready        (o_res.ready),
        .o_status       (o_res.status),
        .o_next_pc      (o_res.next_pc),
        .o_next_segment (o_res.next_segment),
        .o_top_value    (o_res.top_value),
        .o_stack_depth  (o_res.stack_depth),
        .o_call_depth   (o_res.call_depth)
    );

endmodule
`default_nettype wire

// ===== hdl/sme_checker.sv =====
`default_nettype none
module sme_checker
    import sme_pkg::*;
#(
    parameter int STACK_DEPTH = SME_STACK_DEPTH,
    parameter int CALL_DEPTH  = SME_CALL_DEPTH
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        i_ready,
    input wire logic [3:0]  i_status,
    input wire logic [15:0] i_next_pc,
    input wire logic [15:0] i_next_segment,
    input wire logic [63:0] i_top_value,
    input wire logic [10:0] i_stack_depth,
    input wire logic [6:0]  i_call_depth
);

    logic [15:0] r_pc;
    logic [15:0] r_seg;
    logic [63:0] r_top;
    logic [10:0] r_sp;
    logic [6:0]  r_fc;
    logic        acc;

    assign acc = i_valid && i_ready;

    // state shown by the last delivered transaction (zero after reset)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= '0;
            r_seg <= '0;
            r_top <= '0;
            r_sp  <= '0;
            r_fc  <= '0;
        end else if (acc) begin
            r_pc  <= i_next_pc;
            r_seg <= i_next_segment;
            r_top <= i_top_value;
            r_sp  <= i_stack_depth;
            r_fc  <= i_call_depth;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result dropped while stalled");

    a_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |-> (32'(i_stack_depth) <= STACK_DEPTH) && (32'(i_call_depth) <= CALL_DEPTH))
        else $error("depth out of range");

    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_stack_depth == '0 |-> i_top_value == '0)
        else $error("empty stack with nonzero top");

    a_err_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_status != ST_OK |-> i_next_pc == r_pc && i_next_segment == r_seg &&
            i_top_value == r_top && i_stack_depth == r_sp && i_call_depth == r_fc)
        else $error("state changed on a failing instruction");

endmodule

bind stack_machine_execute_unit sme_checker #(
    .STACK_DEPTH (STACK_DEPTH),
    .CALL_DEPTH  (CALL_DEPTH)
) u_sme_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_res.valid),
    .i_ready        (o_res.ready),
    .i_status       (o_res.status),
    .i_next_pc      (o_res.next_pc),
    .i_next_segment (o_res.next_segment),
    .i_top_value    (o_res.top_value),
    .i_stack_depth  (o_res.stack_depth),
    .i_call_depth   (o_res.call_depth)
);
`default_nettype wire

// ===== test/stack_machine_execute_unit_tb.sv =====
`timescale 1ns / 1ps
module stack_machine_execute_unit_tb;
    import sme_pkg::*;

    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int MAX_SHOWN   = 10;

    typedef struct {
        logic [4:0]  op;
        logic [63:0] imm;
        logic [15:0] slot;
        logic [7:0]  nargs;
        logic [7:0]  nlocals;
    } t_instr;

    typedef struct {
        logic [3:0]  status;
        logic [15:0] pc;
        logic [15:0] seg;
        logic [63:0] top;
        logic [10:0] depth;
        logic [6:0]  calls;
    } t_machine_state;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sme_in_if  cmd_if();
    sme_out_if res_if();

    stack_machine_execute_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow machine
    logic [63:0] vstk [SME_STACK_DEPTH];
    logic [63:0] lstore [SME_LOCAL_DEPTH];
    bit          written [SME_LOCAL_DEPTH];
    logic [15:0] ret_pc [SME_CALL_DEPTH];
    logic [15:0] ret_seg [SME_CALL_DEPTH];
    int          ret_base [SME_CALL_DEPTH];
    int          ret_size [SME_CALL_DEPTH];
    int          m_sp, m_base, m_size, m_calls, m_gcount;
    logic [15:0] m_pc, m_seg;

    t_instr         instr_queue[$];
    t_machine_state machine_states[$];

    int  mismatches;
    int  results_seen;
    int  cycles;
    int  send_gap;
    int  recv_stall;
    int  long_hold;
    bit  hold_done;
    bit  quiet;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic void set_global_count(int unsigned value);
        value = value & 32'h7FF;
        m_gcount = (value > SME_LOCAL_DEPTH) ? SME_LOCAL_DEPTH : value;
        if (m_calls == 0)
            m_size = m_gcount;
    endfunction

    function automatic t_machine_state execute_instr(t_instr c);
        t_machine_state r;
        logic [3:0]  st;
        logic [15:0] nxt;
        logic [63:0] a, b, v;
        int nb, lim, addr;
        st  = ST_OK;
        nxt = m_pc + 16'd1;
        case (c.op)
            OP_RETURN: begin
                if (m_calls == 0) begin
                    st = ST_RET_TOP;
                end else begin
                    m_calls = m_calls - 1;
                    nxt    = ret_pc[m_calls];
                    m_seg  = ret_seg[m_calls];
                    m_base = ret_base[m_calls];
                    m_size = ret_size[m_calls];
                end
            end
            OP_CALL: begin
                nb = m_base + m_size;
                if (m_calls >= SME_CALL_DEPTH) st = ST_CALL_OVF;
                else if (c.nargs > c.nlocals) st = ST_INVALID;
                else if (m_sp < c.nargs) st = ST_UNDERFLOW;
                else if (nb + c.nlocals > SME_LOCAL_DEPTH) st = ST_LOCAL_OVF;
                else begin
                    ret_pc[m_calls]   = nxt;
                    ret_seg[m_calls]  = m_seg;
                    ret_base[m_calls] = m_base;
                    ret_size[m_calls] = m_size;
                    m_calls = m_calls + 1;
                    // top of stack lands in the highest argument slot
                    for (int i = c.nargs; i > 0; i--) begin
                        m_sp = m_sp - 1;
                        lstore[nb + i - 1]  = vstk[m_sp];
                        written[nb + i - 1] = 1'b1;
                    end
                    m_base = nb;
                    m_size = c.nlocals;
                    m_seg  = c.slot;
                    nxt    = '0;
                end
            end
            OP_JZ: begin
                if (m_sp < 1) begin
                    st = ST_UNDERFLOW;
                end else begin
                    m_sp = m_sp - 1;
                    if (vstk[m_sp] == 0)
                        nxt = c.slot;
                end
            end
            OP_JUMP: nxt = c.slot;
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_GT, OP_LT, OP_GE, OP_LE,
            OP_EQ, OP_NE: begin
                if (m_sp < 2) begin
                    st = ST_UNDERFLOW;
                end else begin
                    b = vstk[m_sp - 1];
                    a = vstk[m_sp - 2];
                    if ((c.op == OP_DIV || c.op == OP_MOD) && b == 0) begin
                        st = ST_DIV_ZERO;
                    end else begin
                        case (c.op)
                            OP_ADD:  v = a + b;
                            OP_SUB:  v = a - b;
                            OP_MUL:  v = a * b;
                            OP_DIV:  v = a / b;
                            OP_MOD:  v = a % b;
                            OP_GT:   v = {63'd0, a > b};
                            OP_LT:   v = {63'd0, a < b};
                            OP_GE:   v = {63'd0, a >= b};
                            OP_LE:   v = {63'd0, a <= b};
                            OP_EQ:   v = {63'd0, a == b};
                            default: v = {63'd0, a != b};
                        endcase
                        m_sp = m_sp - 1;
                        vstk[m_sp - 1] = v;
                    end
                end
            end
            OP_INC, OP_DEC: begin
                if (m_sp < 1) st = ST_UNDERFLOW;
                else if (c.op == OP_INC) vstk[m_sp - 1] = vstk[m_sp - 1] + 64'd1;
                else vstk[m_sp - 1] = vstk[m_sp - 1] - 64'd1;
            end
            OP_STORE_G, OP_STORE_L: begin
                lim  = (c.op == OP_STORE_G) ? m_gcount : m_size;
                addr = (c.op == OP_STORE_G) ? c.slot : m_base + c.slot;
                if (c.slot >= lim || addr >= SME_LOCAL_DEPTH) st = ST_INVALID;
                else if (m_sp < 1) st = ST_UNDERFLOW;
                else begin
                    m_sp = m_sp - 1;
                    lstore[addr]  = vstk[m_sp];
                    written[addr] = 1'b1;
                end
            end
            OP_LOAD_IMM: begin
                if (m_sp >= SME_STACK_DEPTH) st = ST_OVERFLOW;
                else begin
                    vstk[m_sp] = c.imm;
                    m_sp = m_sp + 1;
                end
            end
            OP_LOAD_G, OP_LOAD_L: begin
                lim  = (c.op == OP_LOAD_G) ? m_gcount : m_size;
                addr = (c.op == OP_LOAD_G) ? c.slot : m_base + c.slot;
                if (c.slot >= lim || addr >= SME_LOCAL_DEPTH) st = ST_INVALID;
                else if (m_sp >= SME_STACK_DEPTH) st = ST_OVERFLOW;
                else begin
                    vstk[m_sp] = lstore[addr];
                    m_sp = m_sp + 1;
                end
            end
            OP_EXIT: st = ST_EXIT;
            default: st = ST_INVALID;
        endcase
        if (st == ST_OK)
            m_pc = nxt;
        r.status = st;
        r.pc     = m_pc;
        r.seg    = m_seg;
        r.top    = (m_sp > 0) ? vstk[m_sp - 1] : 64'd0;
        r.depth  = m_sp[10:0];
        r.calls  = m_calls[6:0];
        return r;
    endfunction

    // a load that would really fetch a never-written slot is redirected out of the frame
    function automatic t_instr avoid_unwritten(t_instr c);
        int lim, addr;
        if (c.op == OP_LOAD_G || c.op == OP_LOAD_L) begin
            lim  = (c.op == OP_LOAD_G) ? m_gcount : m_size;
            addr = (c.op == OP_LOAD_G) ? c.slot : m_base + c.slot;
            if (c.slot < lim && addr < SME_LOCAL_DEPTH && m_sp < SME_STACK_DEPTH
                    && !written[addr])
                c.slot = lim[15:0];
        end
        return c;
    endfunction

    function automatic t_instr make_instr(logic [4:0] op, logic [63:0] imm,
                                          logic [15:0] slot, logic [7:0] nargs,
                                          logic [7:0] nlocals);
        t_instr c;
        c.op = op;
        c.imm = imm;
        c.slot = slot;
        c.nargs = nargs;
        c.nlocals = nlocals;
        return c;
    endfunction

    function automatic t_instr random_instr();
        t_instr c;
        int k, top_args;
        c.op      = OP_LOAD_IMM;
        c.imm     = ($urandom_range(0, 1) == 1) ? {$urandom, $urandom}
                                                : 64'($urandom_range(0, 20));
        c.slot    = 16'($urandom);
        c.nargs   = 8'($urandom);
        c.nlocals = 8'($urandom);
        if ($urandom_range(0, 99) < 12) begin
            c.op = 5'($urandom_range(0, 31));
            return avoid_unwritten(c);
        end
        k = $urandom_range(0, 99);
        if (m_sp < 2 && k < 45)
            k = 0;
        if (m_sp > 60 && k < 25)
            k = 30;
        if (k < 25) begin
            c.op = OP_LOAD_IMM;
        end else if (k < 45) begin
            c.op = 5'($urandom_range(OP_ADD, OP_NE));
        end else if (k < 52) begin
            c.op = ($urandom_range(0, 1) == 1) ? OP_INC : OP_DEC;
        end else if (k < 60) begin
            c.op   = OP_STORE_G;
            c.slot = (m_gcount > 0) ? 16'($urandom_range(0, m_gcount - 1)) : 16'd0;
        end else if (k < 67) begin
            c.op   = OP_STORE_L;
            c.slot = (m_size > 0) ? 16'($urandom_range(0, m_size - 1)) : 16'd0;
        end else if (k < 74) begin
            c.op   = OP_LOAD_G;
            c.slot = (m_gcount > 0) ? 16'($urandom_range(0, m_gcount - 1)) : 16'd0;
        end else if (k < 81) begin
            c.op   = OP_LOAD_L;
            c.slot = (m_size > 0) ? 16'($urandom_range(0, m_size - 1)) : 16'd0;
        end else if (k < 86) begin
            c.op = OP_JZ;
        end else if (k < 89) begin
            c.op = OP_JUMP;
        end else if (k < 94) begin
            c.op      = OP_CALL;
            c.nlocals = 8'($urandom_range(0, 6));
            top_args  = (m_sp < c.nlocals) ? m_sp : c.nlocals;
            c.nargs   = 8'($urandom_range(0, top_args));
        end else if (k < 98) begin
            c.op = OP_RETURN;
        end else begin
            c.op = OP_EXIT;
        end
        return avoid_unwritten(c);
    endfunction

    task automatic issue(t_instr c);
        t_machine_state r;
        r = execute_instr(c);
        instr_queue    = {instr_queue, c};
        machine_states = {machine_states, r};
    endtask

    task automatic drain();
        while (instr_queue.size() != 0 || machine_states.size() != 0 || cmd_if.valid)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_global_count(int unsigned value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'd0;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        set_global_count(value);
    endtask

    task automatic random_run(int count);
        for (int n = 0; n < count; n++)
            issue(random_instr());
    endtask

    task automatic unwind_calls();
        while (m_calls > 0)
            issue(make_instr(OP_RETURN, 64'd0, 16'd0, 8'd0, 8'd0));
    endtask

    // command driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
            send_gap     <= 0;
        end else if (!cmd_if.valid || cmd_if.ready) begin
            if (send_gap > 0) begin
                send_gap     <= send_gap - 1;
                cmd_if.valid <= 1'b0;
            end else if (instr_queue.size() != 0) begin
                t_instr c;
                c = instr_queue.pop_front();
                cmd_if.valid          <= 1'b1;
                cmd_if.operation      <= c.op;
                cmd_if.immediate      <= c.imm;
                cmd_if.target_or_slot <= c.slot;
                cmd_if.arg_count      <= c.nargs;
                cmd_if.local_count    <= c.nlocals;
                if (!quiet && $urandom_range(0, 7) == 0)
                    send_gap <= $urandom_range(1, 14);
            end else begin
                cmd_if.valid <= 1'b0;
            end
        end
    end

    // result ready: random stalls plus one long hold-off so the input side backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            recv_stall   <= 0;
            long_hold    <= 0;
            hold_done    <= 1'b0;
        end else if (long_hold > 0) begin
            long_hold    <= long_hold - 1;
            res_if.ready <= 1'b0;
        end else if (!hold_done && results_seen >= 150) begin
            long_hold    <= 600;
            hold_done    <= 1'b1;
            res_if.ready <= 1'b0;
        end else if (recv_stall > 0) begin
            recv_stall   <= recv_stall - 1;
            res_if.ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            recv_stall   <= $urandom_range(0, 13);
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            t_machine_state e;
            results_seen <= results_seen + 1;
            if (machine_states.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected transaction: status %0d pc %0d",
                             res_if.status, res_if.next_pc);
            end else begin
                e = machine_states.pop_front();
                if (res_if.status !== e.status || res_if.next_pc !== e.pc
                        || res_if.next_segment !== e.seg || res_if.top_value !== e.top
                        || res_if.stack_depth !== e.depth || res_if.call_depth !== e.calls)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= MAX_SHOWN)
                        $display({"mismatch #%0d: exp st %0d pc %0d seg %0d top %h ",
                                  "sp %0d calls %0d / got st %0d pc %0d seg %0d top %h ",
                                  "sp %0d calls %0d"},
                                 results_seen, e.status, e.pc, e.seg, e.top, e.depth,
                                 e.calls, res_if.status, res_if.next_pc,
                                 res_if.next_segment, res_if.top_value,
                                 res_if.stack_depth, res_if.call_depth);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        cmd_if.valid          = 1'b0;
        cmd_if.operation      = '0;
        cmd_if.immediate      = '0;
        cmd_if.target_or_slot = '0;
        cmd_if.arg_count      = '0;
        cmd_if.local_count    = '0;
        res_if.ready = 1'b0;
        mismatches   = 0;
        results_seen = 0;
        cycles       = 0;
        quiet        = 1'b0;
        m_sp = 0; m_base = 0; m_size = 0; m_calls = 0; m_gcount = 0;
        m_pc = '0; m_seg = '0;
        foreach (written[i]) written[i] = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: error paths on an empty machine, then arithmetic extremes
        issue(make_instr(OP_RETURN, 64'd0, 16'd0, 8'd0, 8'd0));
        issue(make_instr(OP_INVALID, 64'd0, 16'd0, 8'd0, 8'd0));
        issue(make_instr(5'd31, 64'd0, 16'd0, 8'd0, 8'd0));
        issue(make_instr(OP_LOAD_L, 64'd0, 16'd0, 8'd0, 8'd0));
        issue(make_instr(OP_JZ, 64'd0, 16'd5, 8'd0, 8'd0));
        issue(make_instr(OP_ADD, 64'd0, 16'd0, 8'd0, 8'd0));
        issue(make_instr(OP_LOAD_IMM, 64'hFFFF_FFFF_FFFF_FFFF, 16'd0, 8'd0, 8'd0));
        issue(make_instr(OP_LOAD_IMM, 64'h8000_0000_0000_0000, 16'd0, 8'd0, 8'd0));
        issue(make_instr(OP_MUL, 64'd0, 16'd0, 8'd0, 8'd0));
        issue(make_instr(OP_LOAD_IMM, 64'd0, 16'd0, 8'd0, 8'd0));
        issue(make_instr(OP_DIV, 64'd0, 16'd0, 8'd0, 8'd0));
        issue(make_instr(OP_MOD, 64'd0, 16'd0, 8'd0, 8'd0));
        issue(make_instr(OP_SUB, 64'd0, 16'd0, 8'd0, 8'd0));
        issue(make_instr(OP_DEC, 64'd0, 16'd0, 8'd0, 8'd0));
        issue(make_instr(OP_INC, 64'd0, 16'd0, 8'd0, 8'd0));
        issue(make_instr(OP_JZ, 64'd0, 16'hFFFF, 8'd0, 8'd0));
        issue(make_instr(OP_LOAD_IMM, 64'h7FFF_FFFF_FFFF_FFFF, 16'd0, 8'd0, 8'd0));
        issue(make_instr(OP_EXIT, 64'd0, 16'd0, 8'd0, 8'd0));
        drain();

        write_global_count(4);
        issue(make_instr(OP_LOAD_IMM, 64'd7, 16'd0, 8'd0, 8'd0));
        issue(make_instr(OP_STORE_G, 64'd0, 16'd3, 8'd0, 8'd0));
        issue(make_instr(OP_STORE_G, 64'd0, 16'd4, 8'd0, 8'd0));
        issue(make_instr(OP_LOAD_G, 64'd0, 16'd3, 8'd0, 8'd0));
        issue(make_instr(OP_LOAD_IMM, 64'd3, 16'd0, 8'd0, 8'd0));
        issue(make_instr(OP_CALL, 64'd0, 16'd9, 8'd3, 8'd2));
        issue(make_instr(OP_CALL, 64'd0, 16'd9, 8'd3, 8'd3));
        issue(make_instr(OP_CALL, 64'd0, 16'hFFFF, 8'd2, 8'd3));
        issue(make_instr(OP_LOAD_L, 64'd0, 16'd1, 8'd0, 8'd0));
        issue(make_instr(OP_STORE_L, 64'd0, 16'd2, 8'd0, 8'd0));
        issue(make_instr(OP_LOAD_L, 64'd0, 16'd3, 8'd0, 8'd0));
        issue(make_instr(OP_LOAD_L, 64'd0, 16'd0, 8'd0, 8'd0));
        issue(make_instr(OP_LOAD_L, 64'd0, 16'd2, 8'd0, 8'd0));
        for (logic [4:0] op = OP_GT; op <= OP_NE; op++) begin
            issue(make_instr(OP_LOAD_IMM, 64'd5, 16'd0, 8'd0, 8'd0));
            issue(make_instr(op, 64'd0, 16'd0, 8'd0, 8'd0));
        end
        issue(make_instr(OP_JUMP, 64'd0, 16'hFFFF, 8'd0, 8'd0));
        issue(make_instr(OP_JZ, 64'd0, 16'd0, 8'd0, 8'd0));
        issue(make_instr(OP_RETURN, 64'd0, 16'd0, 8'd0, 8'd0));
        drain();

        // random programs under several global counts
        write_global_count(12);
        random_run(120);
        drain();
        write_global_count(2047);
        random_run(80);
        unwind_calls();
        drain();
        write_global_count(300);
        random_run(130);
        unwind_calls();
        drain();

        // frame that cannot fit, then an empty frame that does: globals fill the whole local store
        write_global_count(1024);
        issue(make_instr(OP_CALL, 64'd0, 16'd1, 8'd0, 8'd1));
        issue(make_instr(OP_CALL, 64'd0, 16'd1, 8'd0, 8'd0));
        issue(make_instr(OP_RETURN, 64'd0, 16'd0, 8'd0, 8'd0));
        drain();

        // nest to full call depth; change the global count mid-call
        write_global_count(0);
        for (int n = 0; n < 10; n++)
            issue(make_instr(OP_CALL, 64'd0, 16'(n), 8'd0, 8'd0));
        drain();
        write_global_count(1000);
        while (m_calls < SME_CALL_DEPTH)
            issue(make_instr(OP_CALL, 64'd0, 16'($urandom), 8'd0, 8'd0));
        issue(make_instr(OP_CALL, 64'd0, 16'd0, 8'd0, 8'd0));
        unwind_calls();
        drain();

        quiet = 1'b1;
        write_global_count(16);
        random_run(40);
        drain();

        if (mismatches == 0 && machine_states.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/sme_pkg.sv
hdl/sme_in_if.sv
hdl/sme_out_if.sv
hdl/sme_front.sv
hdl/sme_queue.sv
hdl/sme_back.sv
hdl/stack_machine_execute_unit.sv
hdl/sme_checker.sv
test/stack_machine_execute_unit_tb.sv
